/* rtl/date_series_checker_assert.svh */
// Assertion shorthands for the date series checker.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef DATE_SERIES_CHECKER_ASSERT_SVH
`define DATE_SERIES_CHECKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dsc_pkg.sv */
package dsc_pkg;

  localparam int unsigned DAY_W = 23;
  localparam int unsigned GAP_W = 22;
  localparam int unsigned CNT_W = 10;
  localparam int unsigned CFG_W = 22;
  localparam int unsigned DOY_W = 9;
  localparam int unsigned YOE_W = 9;
  localparam int unsigned YY_W  = 15;  // signed, year -1 .. 9999
  localparam int unsigned DOE_W = 18;

  localparam logic [7:0] HYPHEN   = 8'h2D;
  localparam logic [7:0] DIGIT_LO = 8'h30;
  localparam logic [7:0] DIGIT_HI = 8'h39;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [GAP_W-1:0] GAP_MAX   = {GAP_W{1'b1}};

  // Four-digit years give eras 0 .. 24 (plus -1 for year -1).
  localparam int unsigned ERA_MAX       = 24;
  localparam int unsigned ERA_W         = $clog2(ERA_MAX + 1);
  localparam int unsigned YEARS_PER_ERA = 400;
  localparam int unsigned DAYS_PER_ERA  = 146097;
  localparam int unsigned EPOCH_SHIFT   = 719468;

  // Stream layout.
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned OUT_TUSER_W = 1;

  localparam int unsigned OUT_DAY_LSB     = 0;
  localparam int unsigned OUT_SHORT_BIT   = 23;
  localparam int unsigned OUT_VERDICT_LSB = 24;
  localparam int unsigned OUT_GAP_LSB     = 27;
  localparam int unsigned OUT_COUNT_LSB   = 49;

  typedef enum logic [0:0] {
    CFG_MIN_SCENE_COUNT = 1'b0,
    CFG_MAX_GAP_LIMIT   = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    VERDICT_OK          = 3'd0,
    VERDICT_NO_DATES    = 3'd1,
    VERDICT_TRUNCATED   = 3'd2,
    VERDICT_UNPARSEABLE = 3'd3,
    VERDICT_ORDER       = 3'd4,
    VERDICT_GAP         = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [CNT_W-1:0] min_scene_count;
    logic [GAP_W-1:0] max_gap_limit;
  } cfg_t;

  typedef struct packed {
    logic        empty_series;
    logic        short_text;
    logic [31:0] year_chars;
    logic [7:0]  first_separator;
    logic [15:0] month_chars;
    logic [7:0]  second_separator;
    logic [15:0] day_chars;
    logic        last_date;
    logic        provider_truncated;
  } raw_item_t;

  typedef struct packed {
    logic             empty;
    logic             last;
    logic             truncated;
    logic             valid;
    logic [YY_W-1:0]  yy;     // two's complement
    logic [DOY_W-1:0] doy;
  } parsed_t;

  typedef struct packed {
    logic             empty;
    logic             last;
    logic             truncated;
    logic             valid;
    logic [ERA_W:0]   era;    // two's complement
    logic [YOE_W-1:0] yoe;
    logic [DOY_W-1:0] doy;
  } split_t;

  typedef struct packed {
    logic             empty;
    logic             last;
    logic             truncated;
    logic             valid;
    logic [DAY_W-1:0] day;    // two's complement
  } dated_t;

  typedef struct packed {
    logic [DAY_W-1:0] day_number;
    logic             date_valid;
    logic             series_done;
    logic             scenes_short;
    verdict_t         series_verdict;
    logic [GAP_W-1:0] gap_found;
    logic [CNT_W-1:0] dates_seen;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= DIGIT_LO) && (c <= DIGIT_HI);
  endfunction

  // First day of each month in a year that starts in March.
  function automatic logic [DOY_W-1:0] month_start(input logic [3:0] mp);
    logic [DOY_W-1:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

/* rtl/date_series_checker.sv */
// Date series checker. Each input transaction carries one ISO date as ASCII
// text (YYYY-MM-DD) and gets exactly one result transaction. A date is valid
// when short_text is clear, both separators are hyphens, all eight date
// characters are digits, the month is 1..12 and the day 1..31 (day 31 is
// accepted in every month); a valid date is turned into a signed day count
// from 1970-01-01 on the proleptic Gregorian calendar, an invalid one
// reports day 0. Across a series the block tracks the previous valid day,
// whether valid dates ascend, the largest forward gap and a date count that
// saturates at 1023. The transaction with in_tlast set, or with the
// empty-series flag set, closes the series: its result carries out_tlast,
// the short-scene flag and the verdict (first match wins: no dates,
// truncated, unparseable, order invalid, gap exceeded), and the series
// state clears. Throughput is one transaction per clock while out_tready
// stays high; the pipeline has five registers (input, parse, era split,
// day sum, result with the series state). Each stage holds its item while
// the one after it is stalled, so bubbles close up and in_tready stays high
// as long as any stage is free. Configuration writes take effect on the
// next clock and are meant for an idle block; min_scene_count and
// max_gap_limit equal to zero disable their checks.
module date_series_checker
  import dsc_pkg::*;
#(
  parameter int unsigned MAX_DATES = 512  // dates beyond this count mark truncation
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_tvalid,
  output logic                   in_tready,
  // year_chars[31:0], first_separator[39:32], month_chars[55:40],
  // second_separator[63:56], day_chars[79:64]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // empty_series[0], short_text[1], provider_truncated[2]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   in_tlast,   // last_date

  output logic                   out_tvalid,
  input  logic                   out_tready,
  // day_number[22:0], scenes_short[23], series_verdict[26:24],
  // gap_found[48:27], dates_seen[58:49], zero fill [63:59]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // date_valid[0]
  output logic [OUT_TUSER_W-1:0] out_tuser,
  output logic                   out_tlast,  // series_done

  input  logic                   cfg_wr_en,
  input  logic [0:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  cfg_t      cfg_r;
  raw_item_t in_item;

  logic      p_valid, p_ready;
  parsed_t   p_item;
  logic      t_valid, t_ready;
  dated_t    t_item;
  result_t   res;

  // Register writes; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_MIN_SCENE_COUNT: cfg_r.min_scene_count <= cfg_wdata[CNT_W-1:0];
        CFG_MAX_GAP_LIMIT:   cfg_r.max_gap_limit   <= cfg_wdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.empty_series       = in_tuser[0];
    in_item.short_text         = in_tuser[1];
    in_item.provider_truncated = in_tuser[2];
    in_item.year_chars         = in_tdata[31:0];
    in_item.first_separator    = in_tdata[39:32];
    in_item.month_chars        = in_tdata[55:40];
    in_item.second_separator   = in_tdata[63:56];
    in_item.day_chars          = in_tdata[79:64];
    in_item.last_date          = in_tlast;
  end

  // Input register and character parse.
  dsc_date_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_item  (in_item),
    .dn_valid (p_valid),
    .dn_ready (p_ready),
    .dn_item  (p_item)
  );

  // Civil date to day number, two stages.
  dsc_day_count u_days (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (p_valid),
    .up_ready (p_ready),
    .up_item  (p_item),
    .dn_valid (t_valid),
    .dn_ready (t_ready),
    .dn_item  (t_item)
  );

  // Series state and result register.
  dsc_series_track #(
    .MAX_DATES (MAX_DATES)
  ) u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (t_valid),
    .up_ready (t_ready),
    .up_item  (t_item),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_item  (res)
  );

  assign out_tdata = {5'd0, res.dates_seen, res.gap_found, res.series_verdict,
                      res.scenes_short, res.day_number};
  assign out_tuser = res.date_valid;
  assign out_tlast = res.series_done;

endmodule

/* rtl/dsc_date_parse.sv */
module dsc_date_parse
  import dsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  raw_item_t up_item,
  output logic      dn_valid,
  input  logic      dn_ready,
  output parsed_t   dn_item
);

  logic      a_v_r, a_v_nxt, a_en;
  raw_item_t a_r;
  logic      b_v_r, b_v_nxt, b_en;
  parsed_t   b_r, b_nxt;

  logic [3:0]  y3, y2, y1, y0, m1, m0, d1, d0;
  logic        digits_ok, fmt_ok, range_ok, early;
  logic [13:0] year;
  logic [6:0]  month, dom;
  logic [3:0]  mp;

  assign b_en     = !b_v_r || dn_ready;
  assign a_en     = !a_v_r || b_en;
  assign up_ready = a_en;
  assign a_v_nxt  = a_en ? up_valid : a_v_r;
  assign b_v_nxt  = b_en ? a_v_r : b_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en && up_valid) begin
      a_r <= up_item;
    end
    if (b_en && a_v_r) begin
      b_r <= b_nxt;
    end
  end

  // Low nibble of an ASCII digit is its value.
  assign y3 = a_r.year_chars[27:24];
  assign y2 = a_r.year_chars[19:16];
  assign y1 = a_r.year_chars[11:8];
  assign y0 = a_r.year_chars[3:0];
  assign m1 = a_r.month_chars[11:8];
  assign m0 = a_r.month_chars[3:0];
  assign d1 = a_r.day_chars[11:8];
  assign d0 = a_r.day_chars[3:0];

  assign digits_ok = is_digit(a_r.year_chars[31:24]) && is_digit(a_r.year_chars[23:16])
                  && is_digit(a_r.year_chars[15:8])  && is_digit(a_r.year_chars[7:0])
                  && is_digit(a_r.month_chars[15:8]) && is_digit(a_r.month_chars[7:0])
                  && is_digit(a_r.day_chars[15:8])   && is_digit(a_r.day_chars[7:0]);

  assign fmt_ok = !a_r.short_text && (a_r.first_separator == HYPHEN)
               && (a_r.second_separator == HYPHEN) && digits_ok;

  assign year  = 14'(y3) * 14'd1000 + 14'(y2) * 14'd100 + 14'(y1) * 14'd10 + 14'(y0);
  assign month = 7'(m1) * 7'd10 + 7'(m0);
  assign dom   = 7'(d1) * 7'd10 + 7'(d0);

  assign range_ok = (month >= 7'd1) && (month <= 7'd12) && (dom >= 7'd1) && (dom <= 7'd31);

  // Jan and Feb belong to the previous March-based year.
  assign early = (month <= 7'd2);
  assign mp    = early ? (month[3:0] + 4'd9) : (month[3:0] - 4'd3);

  always_comb begin
    b_nxt.empty     = a_r.empty_series;
    b_nxt.last      = a_r.last_date;
    b_nxt.truncated = a_r.provider_truncated;
    b_nxt.valid     = !a_r.empty_series && fmt_ok && range_ok;
    b_nxt.yy        = {1'b0, year} - YY_W'(early);
    b_nxt.doy       = month_start(mp) + DOY_W'(dom) - 9'd1;
  end

  assign dn_valid = b_v_r;
  assign dn_item  = b_r;

endmodule

/* rtl/dsc_day_count.sv */
module dsc_day_count
  import dsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    up_valid,
  output logic    up_ready,
  input  parsed_t up_item,
  output logic    dn_valid,
  input  logic    dn_ready,
  output dated_t  dn_item
);

  logic   c_v_r, c_v_nxt, c_en;
  split_t c_r, c_nxt;
  logic   d_v_r, d_v_nxt, d_en;
  dated_t d_r, d_nxt;

  logic               yy_neg;
  logic [ERA_MAX-1:0] era_ge;
  logic [ERA_W-1:0]   era_cnt;
  logic [YY_W-2:0]    yy_base;

  logic [1:0]          cent;
  logic [DOE_W-1:0]    doe;
  logic signed [DAY_W:0] era_days, day_full;

  assign d_en     = !d_v_r || dn_ready;
  assign c_en     = !c_v_r || d_en;
  assign up_ready = c_en;
  assign c_v_nxt  = c_en ? up_valid : c_v_r;
  assign d_v_nxt  = d_en ? c_v_r : d_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      c_v_r <= c_v_nxt;
      d_v_r <= d_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (c_en && up_valid) begin
      c_r <= c_nxt;
    end
    if (d_en && c_v_r) begin
      d_r <= d_nxt;
    end
  end

  // Era split: bank of threshold compares against multiples of 400 years.
  assign yy_neg = up_item.yy[YY_W-1];

  always_comb begin
    for (int k = 1; k <= ERA_MAX; k++) begin
      era_ge[k-1] = !yy_neg && (up_item.yy[YY_W-2:0] >= 14'(YEARS_PER_ERA * k));
    end
  end

  assign era_cnt = ERA_W'($countones(era_ge));
  assign yy_base = 14'(era_cnt) * 14'(YEARS_PER_ERA);

  always_comb begin
    c_nxt.empty     = up_item.empty;
    c_nxt.last      = up_item.last;
    c_nxt.truncated = up_item.truncated;
    c_nxt.valid     = up_item.valid;
    c_nxt.doy       = up_item.doy;
    // Only year -1 is negative: era -1, last year of that era.
    c_nxt.era       = yy_neg ? {(ERA_W + 1){1'b1}} : {1'b0, era_cnt};
    c_nxt.yoe       = yy_neg ? YOE_W'(YEARS_PER_ERA - 1)
                             : YOE_W'(up_item.yy[YY_W-2:0] - yy_base);
  end

  // Day within era, then the era offset and the shift to 1970-01-01.
  assign cent = (c_r.yoe >= 9'd300) ? 2'd3 :
                (c_r.yoe >= 9'd200) ? 2'd2 :
                (c_r.yoe >= 9'd100) ? 2'd1 : 2'd0;

  assign doe = DOE_W'(c_r.yoe) * DOE_W'(365) + DOE_W'(c_r.yoe[YOE_W-1:2])
             - DOE_W'(cent) + DOE_W'(c_r.doy);

  assign era_days = $signed({{(DAY_W - ERA_W){c_r.era[ERA_W]}}, c_r.era})
                  * $signed((DAY_W + 1)'(DAYS_PER_ERA));

  assign day_full = era_days + $signed({{(DAY_W + 1 - DOE_W){1'b0}}, doe})
                  - $signed((DAY_W + 1)'(EPOCH_SHIFT));

  always_comb begin
    d_nxt.empty     = c_r.empty;
    d_nxt.last      = c_r.last;
    d_nxt.truncated = c_r.truncated;
    d_nxt.valid     = c_r.valid;
    d_nxt.day       = c_r.valid ? day_full[DAY_W-1:0] : '0;
  end

  assign dn_valid = d_v_r;
  assign dn_item  = d_r;

endmodule

/* rtl/dsc_series_track.sv */
module dsc_series_track
  import dsc_pkg::*;
#(
  parameter int unsigned MAX_DATES = 512
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    up_valid,
  output logic    up_ready,
  input  dated_t  up_item,
  output logic    dn_valid,
  input  logic    dn_ready,
  output result_t dn_item
);

  localparam logic [CNT_W-1:0] MAX_DATES_C = CNT_W'(MAX_DATES);

  logic             out_v_r, out_v_nxt, load;
  result_t          out_r, out_nxt;

  logic [DAY_W-1:0] prev_day_r, prev_day_nxt;
  logic [GAP_W-1:0] gap_r, gap_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             order_ok_r, order_ok_nxt;
  logic             parse_ok_r, parse_ok_nxt;
  logic             have_prev_r, have_prev_nxt;

  logic             is_date, done;
  logic [CNT_W-1:0] cnt;
  logic [GAP_W-1:0] gap_upd, gap_sat;
  logic             order_upd, parse_upd;
  logic signed [DAY_W:0] diff;

  assign up_ready  = !out_v_r || dn_ready;
  assign load      = up_ready && up_valid;
  assign out_v_nxt = up_ready ? up_valid : out_v_r;

  assign is_date = !up_item.empty;
  assign done    = up_item.empty || up_item.last;
  assign cnt     = (is_date && (count_r != COUNT_MAX)) ? count_r + 1'b1 : count_r;

  assign diff = $signed({up_item.day[DAY_W-1], up_item.day})
              - $signed({prev_day_r[DAY_W-1], prev_day_r});
  assign gap_sat = (diff[DAY_W-1:GAP_W] != '0) ? GAP_MAX : diff[GAP_W-1:0];

  // Order and gap are judged only between valid dates.
  always_comb begin
    gap_upd   = gap_r;
    order_upd = order_ok_r;
    parse_upd = parse_ok_r;
    if (is_date) begin
      if (!up_item.valid) begin
        parse_upd = 1'b0;
      end else if (have_prev_r) begin
        if (diff[DAY_W]) begin
          order_upd = 1'b0;
        end else if (gap_sat > gap_r) begin
          gap_upd = gap_sat;
        end
      end
    end
  end

  always_comb begin
    out_nxt.day_number     = up_item.day;
    out_nxt.date_valid     = up_item.valid;
    out_nxt.series_done    = done;
    out_nxt.scenes_short   = 1'b0;
    out_nxt.series_verdict = VERDICT_OK;
    out_nxt.gap_found      = gap_upd;
    out_nxt.dates_seen     = cnt;
    if (done) begin
      if (cnt == '0) begin
        out_nxt.series_verdict = VERDICT_NO_DATES;
      end else begin
        out_nxt.scenes_short = (cfg.min_scene_count != '0) && (cnt < cfg.min_scene_count);
        if (up_item.truncated || (cnt > MAX_DATES_C)) begin
          out_nxt.series_verdict = VERDICT_TRUNCATED;
        end else if (!parse_upd) begin
          out_nxt.series_verdict = VERDICT_UNPARSEABLE;
        end else if (!order_upd) begin
          out_nxt.series_verdict = VERDICT_ORDER;
        end else if ((cfg.max_gap_limit != '0) && (cnt >= 10'd2)
                     && (gap_upd > cfg.max_gap_limit)) begin
          out_nxt.series_verdict = VERDICT_GAP;
        end
      end
    end
  end

  always_comb begin
    prev_day_nxt  = prev_day_r;
    gap_nxt       = gap_r;
    count_nxt     = count_r;
    order_ok_nxt  = order_ok_r;
    parse_ok_nxt  = parse_ok_r;
    have_prev_nxt = have_prev_r;
    if (load) begin
      if (done) begin
        prev_day_nxt  = '0;
        gap_nxt       = '0;
        count_nxt     = '0;
        order_ok_nxt  = 1'b1;
        parse_ok_nxt  = 1'b1;
        have_prev_nxt = 1'b0;
      end else begin
        gap_nxt      = gap_upd;
        count_nxt    = cnt;
        order_ok_nxt = order_upd;
        parse_ok_nxt = parse_upd;
        if (up_item.valid) begin
          prev_day_nxt  = up_item.day;
          have_prev_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r     <= 1'b0;
      prev_day_r  <= '0;
      gap_r       <= '0;
      count_r     <= '0;
      order_ok_r  <= 1'b1;
      parse_ok_r  <= 1'b1;
      have_prev_r <= 1'b0;
    end else begin
      out_v_r     <= out_v_nxt;
      prev_day_r  <= prev_day_nxt;
      gap_r       <= gap_nxt;
      count_r     <= count_nxt;
      order_ok_r  <= order_ok_nxt;
      parse_ok_r  <= parse_ok_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign dn_valid = out_v_r;
  assign dn_item  = out_r;

endmodule

/* rtl/dsc_checker.sv */
`include "date_series_checker_assert.svh"

module dsc_checker
  import dsc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser,
  input logic                   out_tlast
);

  logic [DAY_W-1:0] day_number;
  logic             scenes_short;
  logic [2:0]       verdict;
  logic [GAP_W-1:0] gap_found;
  logic [CNT_W-1:0] dates_seen;

  assign day_number   = out_tdata[OUT_DAY_LSB +: DAY_W];
  assign scenes_short = out_tdata[OUT_SHORT_BIT];
  assign verdict      = out_tdata[OUT_VERDICT_LSB +: 3];
  assign gap_found    = out_tdata[OUT_GAP_LSB +: GAP_W];
  assign dates_seen   = out_tdata[OUT_COUNT_LSB +: CNT_W];

  // A stalled result holds.
  `DSC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast),
    "result changed while stalled")

  // Verdict and short flag only on the closing transaction.
  `DSC_ASSERT_NOW(a_verdict_on_close, out_tvalid && !out_tlast,
    (verdict == VERDICT_OK) && !scenes_short,
    "series finding outside closing transaction")

  // An invalid date reports day zero.
  `DSC_ASSERT_NOW(a_invalid_day_zero, out_tvalid && !out_tuser[0],
    day_number == '0, "invalid date with nonzero day number")

  // Zero count only for an empty closing item.
  `DSC_ASSERT_NOW(a_empty_count, out_tvalid && (dates_seen == '0),
    out_tlast && (verdict == VERDICT_NO_DATES) && !scenes_short,
    "zero date count outside empty series")

  // No gap before a second date.
  `DSC_ASSERT_NOW(a_gap_needs_two, out_tvalid && (dates_seen <= 10'd1),
    gap_found == '0, "gap reported with fewer than two dates")

endmodule

bind date_series_checker dsc_checker u_dsc_checker (.*);
